>>> hw/rtl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// No dependencies; used by every module of the block.
`default_nettype none

package mts_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Error codes returned with every result
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One result, packed highest field first
  typedef struct packed {
    logic [OUT_TDATA_W-VALUE_W-VALUE_W-DEPTH_W-3-1:0] pad;
    logic [1:0]         error_code;
    logic               is_empty;
    logic [DEPTH_W-1:0] depth_count;
    value_t             min_value;
    value_t             top_value;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/mts_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Depends on mts_pkg for the value type.
`default_nettype none

module mts_ram #(
  parameter int unsigned ADDR_W = 6
) (
  input  wire                               clk,
  input  wire                               wr_en,
  input  wire [ADDR_W-1:0]                  wr_addr,
  input  wire signed [mts_pkg::VALUE_W-1:0] wr_data,
  input  wire                               rd_en,
  input  wire [ADDR_W-1:0]                  rd_addr,
  output mts_pkg::value_t                   rd_data
);

  mts_pkg::value_t mem [2**ADDR_W];
  mts_pkg::value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/min_tracking_stack_top.sv
// Min-tracking stack: top level with the operation sequencer and result register.
// Depends on mts_pkg and instantiates two mts_ram stores.
`default_nettype none

// A stack of signed 32-bit values that also reports its running minimum.
// Each input transaction is a push, a pop or a read (mode code 3 acts as a
// read); each one returns exactly one result transaction with the top value,
// the minimum, the depth (low 7 bits of the count), an empty flag and an
// error code, all as they stand after the operation. A push on a full stack
// or a pop on an empty one changes nothing and is flagged. Both stacks live
// in synchronous RAMs; the current tops are cached in registers, so push,
// read and a pop on an empty stack need no RAM read and pass straight from
// the idle state to the done state, while a pop that removes a value also
// goes through a read state, because the entry below the top must be fetched
// from the RAM, whose read data is registered. One item is in flight at a
// time; the next input is taken while a finished result still waits in the
// output register, and that item then holds in the done state, stalling the
// input, until the waiting result is claimed. No clearing pass is needed after reset.

module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: [1:0] mode, [33:2] value, [39:34] zero
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,
  // out_tdata: [31:0] top_value, [63:32] min_value, [70:64] depth_count,
  //            [71] is_empty, [73:72] error_code, [79:74] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata
);

  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Counts, cached tops and per-item bookkeeping
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] mcnt_r, mcnt_nxt;
  mts_pkg::value_t  top_r, top_nxt;     // value_store[cnt-1]
  mts_pkg::value_t  mtop_r, mtop_nxt;   // minimum_store[mcnt-1]
  logic [1:0]       err_r, err_nxt;
  logic             pop_min_r, pop_min_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [79:0]      out_data_r, out_data_nxt;

  // Input field split
  logic [1:0]       in_mode;
  mts_pkg::value_t  in_value;

  assign in_mode  = in_tdata[1:0];
  assign in_value = in_tdata[33:2];

  // RAM ports
  logic              v_we, m_we, v_re, m_re;
  logic [ADDR_W-1:0] v_waddr, m_waddr, v_raddr, m_raddr;
  mts_pkg::value_t   v_rdata, m_rdata;

  mts_ram #(.ADDR_W(ADDR_W)) u_value_ram (
    .clk     (clk),
    .wr_en   (v_we),
    .wr_addr (v_waddr),
    .wr_data (in_value),
    .rd_en   (v_re),
    .rd_addr (v_raddr),
    .rd_data (v_rdata)
  );

  mts_ram #(.ADDR_W(ADDR_W)) u_min_ram (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (m_waddr),
    .wr_data (in_value),
    .rd_en   (m_re),
    .rd_addr (m_raddr),
    .rd_data (m_rdata)
  );

  // Push targets the slot at the count; pop fetches the slot two below it
  logic [CNT_W-1:0] cnt_m2, mcnt_m2;
  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign mcnt_m2 = mcnt_r - CNT_W'(2);
  assign v_waddr = cnt_r[ADDR_W-1:0];
  assign m_waddr = mcnt_r[ADDR_W-1:0];
  assign v_raddr = cnt_m2[ADDR_W-1:0];
  assign m_raddr = mcnt_m2[ADDR_W-1:0];

  logic accept, full, empty, min_push, min_pop;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(STACK_DEPTH));
  assign empty     = (cnt_r == '0);
  // Value goes onto the minimum stack when it ties or beats the current minimum
  assign min_push  = (mcnt_r == '0) || (in_value <= mtop_r);
  // Minimum entry leaves with the top when they match
  assign min_pop   = (mcnt_r != '0) && (mtop_r == top_r);

  // Result formed from the post-operation state
  mts_pkg::result_t res;
  logic [31:0]      cnt_ext;
  assign cnt_ext = 32'(cnt_r);

  always_comb begin
    res             = '0;
    res.depth_count = cnt_ext[mts_pkg::DEPTH_W-1:0];
    res.is_empty    = empty;
    res.error_code  = err_r;
    if (!empty) begin
      res.top_value = top_r;
      if ((mcnt_r != '0) && (mtop_r <= top_r)) begin
        res.min_value = mtop_r;
      end else begin
        res.min_value = top_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mcnt_nxt      = mcnt_r;
    top_nxt       = top_r;
    mtop_nxt      = mtop_r;
    err_nxt       = err_r;
    pop_min_nxt   = pop_min_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    v_we          = 1'b0;
    m_we          = 1'b0;
    v_re          = 1'b0;
    m_re          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          err_nxt   = mts_pkg::ERR_OK;
          state_nxt = S_DONE;
          unique case (in_mode)
            mts_pkg::MODE_PUSH: begin
              if (full) begin
                err_nxt = mts_pkg::ERR_FULL;
              end else begin
                v_we    = 1'b1;
                top_nxt = in_value;
                cnt_nxt = cnt_r + CNT_W'(1);
                if (min_push && (mcnt_r != CNT_W'(STACK_DEPTH))) begin
                  m_we     = 1'b1;
                  mtop_nxt = in_value;
                  mcnt_nxt = mcnt_r + CNT_W'(1);
                end
              end
            end
            mts_pkg::MODE_POP: begin
              if (empty) begin
                err_nxt = mts_pkg::ERR_EMPTY;
              end else begin
                // Fetch the new tops; garbage when the stack drains is never shown
                v_re        = 1'b1;
                m_re        = min_pop;
                pop_min_nxt = min_pop;
                cnt_nxt     = cnt_r - CNT_W'(1);
                if (min_pop) begin
                  mcnt_nxt = mcnt_r - CNT_W'(1);
                end
                state_nxt = S_RD;
              end
            end
            default: begin
              // read, and the unused code, change nothing
            end
          endcase
        end
      end
      S_RD: begin
        top_nxt = v_rdata;
        if (pop_min_r) begin
          mtop_nxt = m_rdata;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Wait here only while the previous result is still unclaimed
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      err_r       <= mts_pkg::ERR_OK;
      pop_min_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      pop_min_r   <= pop_min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    mtop_r     <= mtop_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
